FILE: sv/llpc_pkg.sv
`default_nettype none
package llpc_pkg;
  localparam int WinDepth = 22;
  localparam int PatCount = 11;
  localparam int NameLimit = 63;
  localparam int CountW = 32;
  localparam int NumCounts = 5;
  localparam int TokW = 7;

  localparam int P_LOAD = 0;
  localparam int P_IMGAT = 1;
  localparam int P_UNLOAD = 2;
  localparam int P_ACPI = 3;
  localparam int P_INST = 4;
  localparam int P_WARN_U = 5;
  localparam int P_WARN_M = 6;
  localparam int P_FAIL_L = 7;
  localparam int P_FAIL_U = 8;
  localparam int P_FAIL_C = 9;
  localparam int P_ABORT = 10;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;

  // pattern text; the last char lands in the low byte, matching window index 0
  localparam logic [18*8-1:0] PatLoad   = "Loading driver at ";
  localparam logic [16*8-1:0] PatImgAt  = "Error: Image at ";
  localparam logic [22*8-1:0] PatUnload = "start failed: 00000001";
  localparam logic [7*8-1:0]  PatAcpi   = "[ACPI] ";
  localparam logic [11*8-1:0] PatInst   = " Installed ";
  localparam logic [7*8-1:0]  PatWarnU  = "WARNING";
  localparam logic [7*8-1:0]  PatWarnM  = "Warning";
  localparam logic [7*8-1:0]  PatFailL  = " failed";
  localparam logic [7*8-1:0]  PatFailU  = " Failed";
  localparam logic [6*8-1:0]  PatFailC  = "FAILED";
  localparam logic [7*8-1:0]  PatAbort  = "Aborted";
  localparam logic [4*8-1:0]  PatEfi    = ".efi";

  typedef logic [7:0] byte_t;
  typedef byte_t [WinDepth-1:0] window_t;

  // per-cell control handed down the window chain
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;
endpackage
`default_nettype wire

FILE: sv/llpc_cell.sv
`default_nettype none
module llpc_cell (
  input  wire logic clk,
  input  wire llpc_pkg::cell_ctl_t ctl,
  input  wire llpc_pkg::byte_t prev_byte,
  output llpc_pkg::byte_t cur_byte
);
  import llpc_pkg::*;

  byte_t held;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      held <= '0;
    end else if (ctl.shift) begin
      held <= prev_byte;
    end
  end

  assign cur_byte = held;
endmodule
`default_nettype wire

FILE: sv/llpc_window.sv
`default_nettype none
module llpc_window (
  input  wire logic clk,
  input  wire llpc_pkg::cell_ctl_t ctl,
  input  wire llpc_pkg::byte_t in_byte,
  output llpc_pkg::window_t win
);
  import llpc_pkg::*;

  byte_t chain [WinDepth+1];

  assign chain[0] = in_byte;

  for (genvar g = 0; g < WinDepth; g++) begin : g_cell
    llpc_cell u_cell (
      .clk(clk),
      .ctl(ctl),
      .prev_byte(chain[g]),
      .cur_byte(chain[g+1])
    );
    assign win[g] = chain[g+1];
  end
endmodule
`default_nettype wire

FILE: sv/log_line_pattern_classifier.sv
`default_nettype none
// Log line classifier. Accepts one log byte per cycle and returns one beat
// per line end (first CR/LF of a run, or a non-CR/LF end-of-log byte), registered
// at the edge that takes the closing byte and visible the cycle after.
// Bytes shift through a 22-cell window chain; patterns are checked against
// the window as it stands with the incoming byte, so the closing byte of a
// line counts toward its flags. One output register holds the beat; input
// stalls in every cycle where that register holds a beat that m_tready has
// not taken, and runs at one byte per cycle while m_tready stays high.
module log_line_pattern_classifier (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] log_byte
  input  wire logic        s_tlast,   // end_of_log
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [167:0]     m_tdata,   // [0] line_loads_driver, [1] line_image_failed,
                                      // [2] failure_driver_known, [3] line_acpi_install,
                                      // [4] line_warning, [5] line_failure,
                                      // [37:6] drivers_loaded,
                                      // [69:38] image_start_failures,
                                      // [101:70] acpi_installed,
                                      // [133:102] warning_lines,
                                      // [165:134] failure_lines, [167:166] zero
  output logic             m_tlast    // log_done
);
  import llpc_pkg::*;

  logic acc;
  byte_t b;
  logic eol, sep, blank, emit, shift_in;
  cell_ctl_t ctl;
  window_t win, nwin;

  logic [PatCount-1:0] seen, seen_next;
  logic in_run, in_run_next;
  logic [TokW-1:0] tok_len, tok_len_next;
  logic tok_efi, tok_efi_next;
  logic driver_named, driver_named_next;
  logic [CountW-1:0] counts [NumCounts];
  logic [CountW-1:0] counts_next [NumCounts];

  logic [PatCount-1:0] hit, seen_now;
  logic efi_hit, efi_now;

  assign b = s_tdata;
  assign eol = s_tlast;
  assign sep = (b == ChCr) || (b == ChLf);
  assign blank = (b == ChSpace) || (b == ChTab);
  assign s_tready = !m_tvalid || m_tready;
  assign acc = s_tvalid && s_tready;
  assign shift_in = acc && !sep;

  // window as it stands once the incoming byte is in
  assign nwin = {win[WinDepth-2:0], b};

  always_comb begin
    hit = '0;
    if (shift_in) begin
      hit[P_LOAD]   = nwin[$bits(PatLoad)/8-1:0] == PatLoad;
      hit[P_IMGAT]  = nwin[$bits(PatImgAt)/8-1:0] == PatImgAt;
      hit[P_UNLOAD] = nwin[$bits(PatUnload)/8-1:0] == PatUnload;
      hit[P_ACPI]   = nwin[$bits(PatAcpi)/8-1:0] == PatAcpi;
      hit[P_INST]   = nwin[$bits(PatInst)/8-1:0] == PatInst;
      hit[P_WARN_U] = nwin[$bits(PatWarnU)/8-1:0] == PatWarnU;
      hit[P_WARN_M] = nwin[$bits(PatWarnM)/8-1:0] == PatWarnM;
      hit[P_FAIL_L] = nwin[$bits(PatFailL)/8-1:0] == PatFailL;
      hit[P_FAIL_U] = nwin[$bits(PatFailU)/8-1:0] == PatFailU;
      hit[P_FAIL_C] = nwin[$bits(PatFailC)/8-1:0] == PatFailC;
      hit[P_ABORT]  = nwin[$bits(PatAbort)/8-1:0] == PatAbort;
    end
    efi_hit = shift_in && !blank && tok_len >= TokW'(3) && tok_len < TokW'(NameLimit)
              && nwin[$bits(PatEfi)/8-1:0] == PatEfi;
  end

  assign seen_now = seen | hit;

  // a new token drops its efi mark; blanks leave the last token as it is
  always_comb begin
    if (shift_in && !blank) begin
      efi_now = ((tok_len == '0) ? 1'b0 : tok_efi) | efi_hit;
    end else begin
      efi_now = tok_efi;
    end
  end

  assign emit = acc && (sep ? !in_run : eol);

  always_comb begin
    ctl.clear = rst || (acc && (emit || eol));
    ctl.shift = shift_in;
  end

  llpc_window u_window (.clk(clk), .ctl(ctl), .in_byte(b), .win(win));

  logic f_load, f_img, f_acpi, f_warn, f_fail, dn_line;
  logic [CountW-1:0] cnt_inc [NumCounts];
  logic [NumCounts-1:0] inc;

  always_comb begin
    f_load = seen_now[P_LOAD];
    f_img = seen_now[P_IMGAT] && !seen_now[P_UNLOAD];
    f_acpi = seen_now[P_ACPI] && seen_now[P_INST];
    f_warn = seen_now[P_WARN_U] || seen_now[P_WARN_M];
    f_fail = (seen_now[P_FAIL_L] || seen_now[P_FAIL_U] || seen_now[P_FAIL_C]
              || seen_now[P_ABORT]) && !seen_now[P_IMGAT];
    inc = {f_fail, f_warn, f_acpi, f_img, f_load};
    dn_line = f_load ? efi_now : driver_named;
    for (int i = 0; i < NumCounts; i++) begin
      cnt_inc[i] = (inc[i] && counts[i] != '1) ? counts[i] + CountW'(1) : counts[i];
    end
  end

  always_comb begin
    seen_next = seen_now;
    tok_efi_next = efi_now;
    in_run_next = acc ? sep : in_run;
    tok_len_next = tok_len;
    if (shift_in) begin
      if (blank) begin
        tok_len_next = '0;
      end else begin
        tok_len_next = (tok_len != '1) ? tok_len + TokW'(1) : tok_len;
      end
    end
    driver_named_next = driver_named;
    for (int i = 0; i < NumCounts; i++) counts_next[i] = counts[i];
    if (emit) begin
      seen_next = '0;
      tok_len_next = '0;
      tok_efi_next = 1'b0;
      driver_named_next = dn_line;
      for (int i = 0; i < NumCounts; i++) counts_next[i] = cnt_inc[i];
    end
    if (acc && eol) begin
      seen_next = '0;
      in_run_next = 1'b0;
      tok_len_next = '0;
      tok_efi_next = 1'b0;
      driver_named_next = 1'b0;
      for (int i = 0; i < NumCounts; i++) counts_next[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      in_run <= 1'b0;
      tok_len <= '0;
      tok_efi <= 1'b0;
      driver_named <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NumCounts; i++) counts[i] <= '0;
    end else begin
      seen <= seen_next;
      in_run <= in_run_next;
      tok_len <= tok_len_next;
      tok_efi <= tok_efi_next;
      driver_named <= driver_named_next;
      for (int i = 0; i < NumCounts; i++) counts[i] <= counts_next[i];
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (emit) begin
        m_tlast <= eol;
        m_tdata <= {2'b00, cnt_inc[4], cnt_inc[3], cnt_inc[2], cnt_inc[1],
                    cnt_inc[0], f_fail, f_warn, f_acpi, f_img && dn_line, f_img, f_load};
      end
    end
  end

`ifndef SYNTHESIS
  a_no_emit_when_busy: assert property (@(posedge clk) disable iff (rst)
    emit |-> s_tready) else $error("line end taken while output busy");
  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_tvalid) else $error("line end lost");
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    (acc && eol) |=> (counts[0] == '0 && !driver_named)) else $error("counts not cleared");
  a_fdk_implies_img: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[2] || m_tdata[1])) else $error("driver flag without failure");
`endif
endmodule
`default_nettype wire
